// ----- design/pgrp_pkg.sv -----
package pgrp_pkg;

	localparam int FIELD_BITS    = 32;
	localparam int CNT_BITS      = 32;
	localparam int TIMEOUT_BITS  = 16;
	localparam int SHIFT_BITS    = 3;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [TIMEOUT_BITS-1:0] RESET_TIMEOUT = 16'd2000;
	localparam logic [SHIFT_BITS-1:0]   RESET_SHIFT   = 3'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOL_SHIFT = 1'b1;

	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_APPLY
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] start_time;
		logic [FIELD_BITS-1:0] end_time;
		logic [CNT_BITS-1:0]   pulses;
		logic                  timeout;
	} group_rec_t;

endpackage

// ----- design/pgrp_fifo.sv -----
module pgrp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("item pushed into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("item popped from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue fill count out of step");

endmodule

// ----- design/pgrp_front.sv -----
module pgrp_front #(
	parameter int TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [pgrp_pkg::FIELD_BITS-1:0]     time_ms,
	input  logic                                cfg_we,
	input  logic [pgrp_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [pgrp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                full,
	output logic                                push,
	output pgrp_pkg::group_rec_t                rec,
	output logic [TIME_BITS-1:0]                ptot
);

	import pgrp_pkg::*;

	front_state_t state_q;
	front_state_t state_d;

	logic [TIMEOUT_BITS-1:0] timeout_q;
	logic [SHIFT_BITS-1:0]   shift_q;

	logic                 op_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS-1:0] tol_q;
	logic                 idle_q;

	logic                 in_group_q;
	logic [TIME_BITS-1:0] first_q;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] act_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [CNT_BITS-1:0]  pulses_q;
	logic [TIME_BITS-1:0] ptot_q;

	logic [TIME_BITS-1:0] timeout_ext;
	logic [TIME_BITS-1:0] period_c;
	logic [TIME_BITS-1:0] elapsed_c;
	logic [TIME_BITS-1:0] tol_c;
	logic [TIME_BITS-1:0] diff_c;
	logic [TIME_BITS:0]   sum_c;
	logic                 mismatch_c;
	logic                 multi_c;
	logic                 close_tick_c;
	logic                 emit_c;
	logic                 accept;

	assign timeout_ext = TIME_BITS'(timeout_q);
	assign period_c    = t_q - last_q;
	assign elapsed_c   = t_q - act_q;
	assign tol_c       = (prev_q != '0) ? (prev_q >> shift_q) : timeout_ext;

	assign diff_c     = (period_q > prev_q) ? (period_q - prev_q) : (prev_q - period_q);
	assign mismatch_c = (diff_c > tol_q);
	assign sum_c      = {1'b0, ptot_q} + {1'b0, period_q};
	assign multi_c    = (pulses_q > CNT_BITS'(1));

	assign close_tick_c = (op_q == OP_TICK) && in_group_q && idle_q;
	assign emit_c = multi_c && (close_tick_c ||
		((op_q == OP_PULSE) && in_group_q && mismatch_c));

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_CALC;
				end
			end
			F_CALC:  state_d = F_APPLY;
			F_APPLY: state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == F_IDLE) && !full;
		accept          = in_valid && in_ready;
		push            = (state_q == F_APPLY) && emit_c;
		rec.start_time  = FIELD_BITS'(first_q);
		rec.end_time    = FIELD_BITS'(last_q);
		rec.pulses      = pulses_q;
		rec.timeout     = (op_q == OP_TICK);
		ptot            = ptot_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			t_q  <= TIME_BITS'(time_ms);
		end
		if (state_q == F_CALC) begin
			period_q <= period_c;
			tol_q    <= tol_c;
			idle_q   <= (elapsed_c >= timeout_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			timeout_q <= RESET_TIMEOUT;
			shift_q   <= RESET_SHIFT;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIMEOUT:   timeout_q <= TIMEOUT_BITS'(cfg_wdata);
					REG_TOL_SHIFT: shift_q   <= cfg_wdata[SHIFT_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_group_q <= 1'b0;
			first_q    <= '0;
			last_q     <= '0;
			act_q      <= '0;
			prev_q     <= '0;
			pulses_q   <= '0;
			ptot_q     <= '0;
		end else if (state_q == F_APPLY) begin
			if (op_q == OP_TICK) begin
				if (close_tick_c) begin
					in_group_q <= 1'b0;
					first_q    <= '0;
					last_q     <= '0;
					prev_q     <= '0;
					pulses_q   <= '0;
					ptot_q     <= '0;
				end
			end else if (!in_group_q) begin
				act_q      <= t_q;
				in_group_q <= 1'b1;
				first_q    <= t_q;
				last_q     <= t_q;
				prev_q     <= '0;
				pulses_q   <= CNT_BITS'(1);
				ptot_q     <= '0;
			end else begin
				act_q  <= t_q;
				prev_q <= period_q;
				last_q <= t_q;
				if (mismatch_c) begin
					first_q  <= last_q;
					pulses_q <= CNT_BITS'(2);
					ptot_q   <= period_q;
				end else begin
					if (pulses_q != '1) begin
						pulses_q <= pulses_q + 1'b1;
					end
					ptot_q <= sum_c[TIME_BITS] ? '1 : sum_c[TIME_BITS-1:0];
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_group_q |-> (pulses_q == '0 && ptot_q == '0 && prev_q == '0))
		else $error("closed group left state behind");
	assert property (@(posedge clk) disable iff (!arst_n) in_group_q |-> (pulses_q != '0))
		else $error("open group with no pulse");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_APPLY) |-> ($past(state_q) == F_CALC))
		else $error("apply without calculation");

endmodule

// ----- design/pgrp_back.sv -----
module pgrp_back #(
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fifo_valid,
	input  pgrp_pkg::group_rec_t             rec_in,
	input  logic [TIME_BITS-1:0]             ptot_in,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pgrp_pkg::FIELD_BITS-1:0]  start_time,
	output logic [pgrp_pkg::FIELD_BITS-1:0]  end_time,
	output logic [pgrp_pkg::FIELD_BITS-1:0]  group_pulses,
	output logic [pgrp_pkg::FIELD_BITS-1:0]  average_period,
	output logic                             closed_by_timeout
);

	import pgrp_pkg::*;

	localparam int STEP_W = $clog2(TIME_BITS + 1);

	back_state_t state_q;
	back_state_t state_d;

	group_rec_t           rec_q;
	logic [CNT_BITS-1:0]  div_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [TIME_BITS-1:0] quo_q;
	logic [STEP_W-1:0]    step_q;

	logic                  out_valid_q;
	group_rec_t            out_rec_q;
	logic [FIELD_BITS-1:0] avg_q;

	logic [CNT_BITS:0]   rem_sh;
	logic                ge;
	logic [CNT_BITS-1:0] rem_next;
	logic                load_out;

	assign rem_sh   = {rem_q, quo_q[TIME_BITS-1]};
	assign ge       = (rem_sh >= {1'b0, div_q});
	assign rem_next = ge ? CNT_BITS'(rem_sh - {1'b0, div_q}) : CNT_BITS'(rem_sh);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (fifo_valid) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (step_q == STEP_W'(1)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (load_out) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop               = (state_q == B_IDLE) && fifo_valid;
		load_out          = (state_q == B_DONE) && (!out_valid_q || out_ready);
		out_valid         = out_valid_q;
		start_time        = out_rec_q.start_time;
		end_time          = out_rec_q.end_time;
		group_pulses      = out_rec_q.pulses;
		closed_by_timeout = out_rec_q.timeout;
		average_period    = avg_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q  <= rec_in;
			div_q  <= rec_in.pulses - 1'b1;
			rem_q  <= '0;
			quo_q  <= ptot_in;
			step_q <= STEP_W'(TIME_BITS);
		end else if (state_q == B_DIV) begin
			rem_q  <= rem_next;
			quo_q  <= {quo_q[TIME_BITS-2:0], ge};
			step_q <= step_q - 1'b1;
		end
		if (load_out) begin
			out_rec_q <= rec_q;
			avg_q     <= FIELD_BITS'(quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == B_DIV) |-> (div_q != '0))
		else $error("divide by zero");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == B_DIV) |-> (step_q != '0))
		else $error("divider step count ran out");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == B_DONE))
		else $error("result shown before divide finished");

endmodule

// ----- design/pulse_train_grouper.sv -----
// An item that closes a group passes the front's calc and apply states, the group queue and the back's divider.
// The front handles each item in steps (accept, compute period, update state) and takes no new item until idle again.
// Each emitted group then goes through the bit-serial divider for the average, one group at a time.
// A group queue of QUEUE_DEPTH entries lets the front keep taking items during a divide.
// Reset (arst_n low, asynchronous) clears group state, queue and output valid and
// returns timeout to 2000 ms and tolerance shift to 3.
module pulse_train_grouper #(
	parameter int TIME_BITS   = 32,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [pgrp_pkg::FIELD_BITS-1:0]     time_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pgrp_pkg::FIELD_BITS-1:0]     start_time,
	output logic [pgrp_pkg::FIELD_BITS-1:0]     end_time,
	output logic [pgrp_pkg::FIELD_BITS-1:0]     group_pulses,
	output logic [pgrp_pkg::FIELD_BITS-1:0]     average_period,
	output logic                                closed_by_timeout,
	input  logic                                cfg_we,
	input  logic [pgrp_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [pgrp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	import pgrp_pkg::*;

	localparam int REC_BITS = $bits(group_rec_t);
	localparam int Q_WIDTH  = REC_BITS + TIME_BITS;

	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	group_rec_t           front_rec;
	group_rec_t           back_rec;
	logic [TIME_BITS-1:0] front_ptot;
	logic [TIME_BITS-1:0] back_ptot;
	logic [Q_WIDTH-1:0]   q_wdata;
	logic [Q_WIDTH-1:0]   q_rdata;

	assign q_wdata   = {front_rec, front_ptot};
	assign back_rec  = q_rdata[Q_WIDTH-1:TIME_BITS];
	assign back_ptot = q_rdata[TIME_BITS-1:0];

	pgrp_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.time_ms   (time_ms),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.full      (full),
		.push      (push),
		.rec       (front_rec),
		.ptot      (front_ptot)
	);

	pgrp_fifo #(
		.WIDTH(Q_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (full),
		.empty  (empty)
	);

	pgrp_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.fifo_valid        (!empty),
		.rec_in            (back_rec),
		.ptot_in           (back_ptot),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.start_time        (start_time),
		.end_time          (end_time),
		.group_pulses      (group_pulses),
		.average_period    (average_period),
		.closed_by_timeout (closed_by_timeout)
	);

endmodule

// ----- test/pulse_train_grouper_tb.sv -----
`timescale 1ns / 1ps

class group_scoreboard;
	typedef struct {
		logic [31:0] start_ms;
		logic [31:0] stop_ms;
		logic [31:0] pulses;
		logic [31:0] avg_period;
		logic        by_timeout;
	} group_t;

	logic [15:0] timeout_ms  = pgrp_pkg::RESET_TIMEOUT;
	logic [2:0]  tol_shift   = pgrp_pkg::RESET_SHIFT;
	bit          open_group  = 1'b0;
	logic [31:0] first_ms    = '0;
	logic [31:0] last_ms     = '0;
	logic [31:0] activity_ms = '0;
	logic [31:0] prev_period = '0;
	logic [31:0] pulse_cnt   = '0;
	logic [31:0] period_sum  = '0;
	group_t      expected_groups[$];
	int          mismatches  = 0;

	function void write_reg(logic [pgrp_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] data);
		if (idx == pgrp_pkg::REG_TIMEOUT) begin
			timeout_ms = data;
		end else if (idx == pgrp_pkg::REG_TOL_SHIFT) begin
			tol_shift = data[2:0];
		end
	endfunction

	function int pending();
		return expected_groups.size();
	endfunction

	function void close_group(bit by_timeout);
		group_t g;
		if (pulse_cnt > 1) begin
			g.start_ms   = first_ms;
			g.stop_ms    = last_ms;
			g.pulses     = pulse_cnt;
			g.avg_period = period_sum / (pulse_cnt - 1);
			g.by_timeout = by_timeout;
			expected_groups.push_back(g);
		end
	endfunction

	// Returns 0 for a tick that finds no open group.
	function bit note_item(logic o, logic [31:0] t);
		logic [31:0] idle_ms;
		logic [31:0] period;
		logic [31:0] tol;
		logic [31:0] diff;
		bit          was_open;
		was_open = open_group;
		if (o == pgrp_pkg::OP_TICK) begin
			idle_ms = t - activity_ms;
			if (open_group && idle_ms >= {16'd0, timeout_ms}) begin
				close_group(1'b1);
				open_group  = 1'b0;
				first_ms    = '0;
				last_ms     = '0;
				prev_period = '0;
				pulse_cnt   = '0;
				period_sum  = '0;
			end
			return was_open;
		end
		activity_ms = t;
		if (!open_group) begin
			open_group  = 1'b1;
			first_ms    = t;
			last_ms     = t;
			pulse_cnt   = 32'd1;
			period_sum  = '0;
			prev_period = '0;
			return 1'b1;
		end
		period = t - last_ms;
		tol    = (prev_period != 0) ? (prev_period >> tol_shift) : {16'd0, timeout_ms};
		diff   = (period > prev_period) ? (period - prev_period) : (prev_period - period);
		if (diff > tol) begin
			close_group(1'b0);
			first_ms   = last_ms;
			pulse_cnt  = 32'd2;
			period_sum = period;
		end else begin
			if (pulse_cnt != '1)
				pulse_cnt = pulse_cnt + 1;
			period_sum = (period > ~period_sum) ? '1 : period_sum + period;
		end
		prev_period = period;
		last_ms     = t;
		return 1'b1;
	endfunction

	function void check_group(logic [31:0] s, logic [31:0] e, logic [31:0] n,
			logic [31:0] a, logic tmo);
		group_t x;
		if (expected_groups.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected group: start=%h stop=%h pulses=%0d avg=%0d timeout=%b",
					s, e, n, a, tmo);
			return;
		end
		x = expected_groups.pop_front();
		if (x.start_ms !== s || x.stop_ms !== e || x.pulses !== n ||
				x.avg_period !== a || x.by_timeout !== tmo) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("group mismatch: expected start=%h stop=%h pulses=%0d avg=%0d timeout=%b",
					x.start_ms, x.stop_ms, x.pulses, x.avg_period, x.by_timeout);
				$display("                got      start=%h stop=%h pulses=%0d avg=%0d timeout=%b",
					s, e, n, a, tmo);
			end
		end
	endfunction
endclass

module pulse_train_grouper_tb;
	import pgrp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 48;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 240;
	localparam int TMO_SET[PHASES] = '{2000, 65535, 1, 0, 400, 0};
	localparam int SHF_SET[PHASES] = '{3, 7, 0, 5, 1, 0};
	localparam int IDLE_SET[PHASES] = '{25, 0, 50, 15, 35, 0};

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic                     op        = OP_PULSE;
	logic [FIELD_BITS-1:0]    time_ms   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [FIELD_BITS-1:0]    start_time;
	logic [FIELD_BITS-1:0]    end_time;
	logic [FIELD_BITS-1:0]    group_pulses;
	logic [FIELD_BITS-1:0]    average_period;
	logic                     closed_by_timeout;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_idx   = REG_TIMEOUT;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	group_scoreboard sb = new;
	int              idle_pct     = 0;
	int              stall_left   = 0;
	int              useful_items = 0;
	int unsigned     cur_timeout  = RESET_TIMEOUT;
	int unsigned     cur_shift    = RESET_SHIFT;
	int unsigned     cycle_cnt    = 0;
	logic [31:0]     now_ms       = '0;

	pulse_train_grouper DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.op                (op),
		.time_ms           (time_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.start_time        (start_time),
		.end_time          (end_time),
		.group_pulses      (group_pulses),
		.average_period    (average_period),
		.closed_by_timeout (closed_by_timeout),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("pulse_train_grouper_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 15);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_group(start_time, end_time, group_pulses, average_period, closed_by_timeout);
	end

	task automatic send(input logic o, input logic [31:0] t);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		time_ms  <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (sb.note_item(o, t))
			useful_items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned tmo, input int unsigned shf);
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_TIMEOUT;
		cfg_wdata <= 16'(tmo);
		@(posedge clk);
		sb.write_reg(REG_TIMEOUT, 16'(tmo));
		cfg_idx   <= REG_TOL_SHIFT;
		cfg_wdata <= 16'(shf);
		@(posedge clk);
		sb.write_reg(REG_TOL_SHIFT, 16'(shf));
		cfg_we      <= 1'b0;
		cur_timeout = tmo & 32'hFFFF;
		cur_shift   = shf & 32'h7;
	endtask

	task automatic directed_items();
		send(OP_TICK,  32'd100);
		send(OP_PULSE, 32'd1000);
		send(OP_PULSE, 32'd1000);
		send(OP_PULSE, 32'd1100);
		send(OP_PULSE, 32'd1200);
		send(OP_PULSE, 32'd1205);
		send(OP_PULSE, 32'd9000);
		send(OP_TICK,  32'd10999);
		send(OP_TICK,  32'd11000);
		send(OP_PULSE, 32'hFFFF_FF00);
		send(OP_PULSE, 32'h0000_0000);
		send(OP_PULSE, 32'h0000_0100);
		send(OP_TICK,  32'hFFFF_FFFF);
		send(OP_PULSE, 32'd5000);
		send(OP_PULSE, 32'd9000);
		send(OP_PULSE, 32'd13000);
		send(OP_TICK,  32'd15000);
		send(OP_PULSE, 32'h0000_0000);
		send(OP_PULSE, 32'hC000_0000);
		send(OP_PULSE, 32'h8000_0000);
		send(OP_TICK,  32'h8000_07D0);
		send(OP_PULSE, 32'd7);
		send(OP_TICK,  32'h7FFF_FFFF);
		set_config(0, RESET_SHIFT);
		send(OP_PULSE, 32'd50);
		send(OP_PULSE, 32'd60);
		send(OP_TICK,  32'd60);
		send(OP_TICK,  32'd61);
	endtask

	task automatic run_phase(input int target);
		int unsigned per;
		int unsigned jit;
		int unsigned stride;
		logic [31:0] last_pulse;
		useful_items = 0;
		last_pulse   = now_ms;
		while (useful_items < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
					if ($urandom_range(0, 19) == 0)
						now_ms = $urandom();
					now_ms = now_ms + $urandom_range(0, 64);
					per = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 100000)
						: $urandom_range(0, 300);
					repeat ($urandom_range(1, 10)) begin
						send(OP_PULSE, now_ms);
						last_pulse = now_ms;
						if ($urandom_range(0, 7) == 0)
							per = $urandom_range(0, 400);
						jit    = $urandom_range(0, per >> cur_shift);
						stride = $urandom_range(0, 1) ? per + jit : per - jit;
						if ($urandom_range(0, 9) == 0)
							send(OP_TICK, last_pulse + $urandom_range(0, stride));
						now_ms = last_pulse + stride;
					end
					case ($urandom_range(0, 4))
						0, 1, 2: begin
							send(OP_TICK, last_pulse + cur_timeout + $urandom_range(0, 2));
							now_ms = last_pulse + cur_timeout;
						end
						3: begin
							send(OP_TICK, last_pulse + cur_timeout - 1);
							send(OP_TICK, last_pulse + cur_timeout);
							now_ms = last_pulse + cur_timeout;
						end
						default: ;
					endcase
				end
				14, 15, 16:
					send(OP_TICK, last_pulse + $urandom_range(0, 2 * cur_timeout + 1));
				default:
					send(logic'($urandom_range(0, 1)), $urandom());
			endcase
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 20;
		now_ms   = $urandom();
		directed_items();
		for (int i = 0; i < PHASES; i++) begin
			idle_pct = IDLE_SET[i];
			if (i == PHASES - 1)
				set_config($urandom_range(1, 65535), $urandom_range(0, 7));
			else
				set_config(TMO_SET[i], SHF_SET[i]);
			run_phase(PHASE_ITEMS);
		end
		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("pulse_train_grouper_tb OK");
		end else begin
			$display("pulse_train_grouper_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/pgrp_pkg.sv
design/pgrp_fifo.sv
design/pgrp_front.sv
design/pgrp_back.sv
design/pulse_train_grouper.sv
test/pulse_train_grouper_tb.sv
